// ===== sv/u8d_pkg.sv =====
`timescale 1ns / 1ps
package u8d_pkg;

    // Queue and result buffer sizes (both four entries)
    localparam int Q_AW   = 2;
    localparam int Q_DEPTH = 1 << Q_AW;
    localparam int R_AW   = 2;
    localparam int R_DEPTH = 1 << R_AW;

    localparam int CP_W   = 21;
    localparam int DATA_W = 24;

    // Byte classes
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Classified input byte, as it travels from the front to the back
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
        logic       is_cont;
        logic       is_ascii;
        logic [1:0] extra;
        logic [4:0] lead_bits;
    } t_cls;

    // One result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            cut_short;
        logic            end_of_run;
    } t_res;

endpackage

// ===== sv/u8d_front.sv =====
`timescale 1ns / 1ps
module u8d_front (
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // in_byte [7:0]
    input  logic            s_axis_tlast,   // last_byte
    input  logic            i_q_full,
    output logic            o_q_push,
    output u8d_pkg::t_cls   o_q_item
);
    import u8d_pkg::*;

    logic [1:0] extra;

    // Accept whenever the queue has room
    assign s_axis_tready = !i_q_full;
    assign o_q_push      = s_axis_tvalid && !i_q_full;

    // Count expected continuations from the lead byte
    always_comb begin
        if (s_axis_tdata >= 8'hF0) begin
            extra = 2'd3;
        end else if (s_axis_tdata >= 8'hE0) begin
            extra = 2'd2;
        end else begin
            extra = 2'd1;
        end
    end

    // Classify the byte
    always_comb begin
        o_q_item.in_byte   = s_axis_tdata;
        o_q_item.last_byte = s_axis_tlast;
        o_q_item.is_cont   = (s_axis_tdata[7:6] == CONT_TAG);
        o_q_item.is_ascii  = !s_axis_tdata[7];
        o_q_item.extra     = extra;
        o_q_item.lead_bits = s_axis_tdata[4:0] & (5'h1F >> (extra - 2'd1));
    end

endmodule

// ===== sv/u8d_queue.sv =====
`timescale 1ns / 1ps
module u8d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8d_pkg::t_cls   i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output u8d_pkg::t_cls   o_item
);
    import u8d_pkg::*;

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic [Q_AW:0]   n_cnt;
    logic            pop_ok;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_comb begin
        n_cnt = r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(pop_ok);
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/u8d_back.sv =====
`timescale 1ns / 1ps
module u8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  u8d_pkg::t_cls   i_q_item,
    output logic            o_q_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [23:0]     m_axis_tdata,   // code_point [20:0], zero fill [23:21]
    output logic            m_axis_tuser,   // cut_short
    output logic            m_axis_tlast    // end_of_run
);
    import u8d_pkg::*;

    // Decoder state
    logic [1:0]      r_rem;
    logic [CP_W-1:0] r_part;
    logic [1:0]      n_rem;
    logic [CP_W-1:0] n_part;

    // Result buffer
    t_res            r_buf [R_DEPTH];
    logic [R_AW-1:0] r_wr;
    logic [R_AW-1:0] r_rd;
    logic [R_AW:0]   r_cnt;

    logic            e0_v, e1_v;
    t_res            e0, e1;
    logic [CP_W-1:0] shifted;
    logic            step;
    logic            out_pop;
    logic [1:0]      n_push;
    t_res            w0, w1;

    assign shifted = {r_part[CP_W-7:0], i_q_item.in_byte[5:0]};

    // Take the next item only when two result slots are free
    assign step    = i_q_valid && (r_cnt <= (R_AW+1)'(R_DEPTH - 2));
    assign o_q_pop = step;
    assign out_pop = m_axis_tvalid && m_axis_tready;

    // Work out the results of the head item and the next state
    always_comb begin
        e0_v   = 1'b0;
        e1_v   = 1'b0;
        e0     = '0;
        e1     = '0;
        n_rem  = r_rem;
        n_part = r_part;
        if (r_rem != 2'd0 && i_q_item.is_cont) begin
            // Continuation byte
            n_rem  = r_rem - 2'd1;
            n_part = shifted;
            if (r_rem == 2'd1) begin
                e0_v   = 1'b1;
                e0     = '{code_point: shifted, cut_short: 1'b0, end_of_run: 1'b1};
                n_part = '0;
            end else if (i_q_item.last_byte) begin
                e0_v   = 1'b1;
                e0     = '{code_point: shifted, cut_short: 1'b1, end_of_run: 1'b1};
                n_rem  = 2'd0;
                n_part = '0;
            end
        end else begin
            // Flush an interrupted character
            if (r_rem != 2'd0) begin
                e0_v   = 1'b1;
                e0     = '{code_point: r_part, cut_short: 1'b1, end_of_run: 1'b0};
                n_rem  = 2'd0;
                n_part = '0;
            end
            // Start a new character
            if (i_q_item.is_ascii) begin
                e1_v = 1'b1;
                e1   = '{code_point: CP_W'(i_q_item.in_byte), cut_short: 1'b0,
                         end_of_run: 1'b1};
            end else if (i_q_item.last_byte) begin
                e1_v = 1'b1;
                e1   = '{code_point: CP_W'(i_q_item.lead_bits), cut_short: 1'b1,
                         end_of_run: 1'b1};
            end else begin
                n_rem  = i_q_item.extra;
                n_part = CP_W'(i_q_item.lead_bits);
            end
            // Mark the first result as the last one when no second follows
            if (!e1_v) begin
                e0.end_of_run = 1'b1;
            end
        end
    end

    // Pack results towards the head of the buffer
    always_comb begin
        w0     = e0_v ? e0 : e1;
        w1     = e1;
        n_push = 2'(e0_v) + 2'(e1_v);
        if (!step) begin
            n_push = 2'd0;
        end
    end

    // Update decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 2'd0;
            r_part <= '0;
        end else if (step) begin
            r_rem  <= n_rem;
            r_part <= n_part;
        end
    end

    // Write results
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_buf[r_wr] <= w0;
        end
        if (n_push == 2'd2) begin
            r_buf[r_wr + R_AW'(1)] <= w1;
        end
    end

    // Advance buffer pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + R_AW'(n_push);
            if (out_pop) begin
                r_rd <= r_rd + R_AW'(1);
            end
            r_cnt <= r_cnt + (R_AW+1)'(n_push) - (R_AW+1)'(out_pop);
        end
    end

    // Drive the output from the buffer head
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {(DATA_W - CP_W)'(0), r_buf[r_rd].code_point};
    assign m_axis_tuser  = r_buf[r_rd].cut_short;
    assign m_axis_tlast  = r_buf[r_rd].end_of_run;

endmodule

// ===== sv/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 stream decoder. One byte enters per item on the slave side (tlast marks
// the final byte of a string) and decoded code points leave on the master side,
// with tuser set when a character was cut short and tlast on the last result that
// a byte yields. A byte is taken in every cycle while the four-entry byte queue
// has room; the decoder back end retires one byte per cycle while two result slots
// are free and writes up to two results into a four-entry result buffer, so a byte
// that interrupts a character yields two results. Bytes wait in the byte queue
// and their results in the result buffer before they leave.
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // code_point [20:0], zero fill [23:21]
    output logic        m_axis_tuser,   // cut_short
    output logic        m_axis_tlast    // end_of_run
);
    import u8d_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cls q_in;
    t_cls q_out;

    // Accept and classify bytes
    u8d_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    // Hold classified bytes between front and back
    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    // Decode and deliver results
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
